### rtl/core/dst_pkg.sv
// Shared types and codes for the descriptor slot table.
`default_nettype none

package dst_pkg;

    typedef enum logic [1:0] {
        MODE_ASSIGN = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_SET    = 2'd2,
        MODE_GET    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_FD     = 3'd1;
    localparam logic [2:0] ST_IN_USE     = 3'd2;
    localparam logic [2:0] ST_NO_MEMORY  = 3'd3;
    localparam logic [2:0] ST_WRONG_TYPE = 3'd4;
    localparam logic [2:0] ST_NO_CONSOLE = 3'd5;

    localparam logic [2:0] REG_STDIN_HANDLE  = 3'd0;
    localparam logic [2:0] REG_STDOUT_HANDLE = 3'd1;
    localparam logic [2:0] REG_STDERR_HANDLE = 3'd2;
    localparam logic [2:0] REG_STDIN_KIND    = 3'd3;
    localparam logic [2:0] REG_STDOUT_KIND   = 3'd4;
    localparam logic [2:0] REG_STDERR_KIND   = 3'd5;

    localparam int HANDLE_W = 32;
    localparam int KIND_W   = 4;
    localparam int FIRST_FREE_SLOT = 3;

    typedef struct packed {
        t_mode              mode;
        logic [7:0]         slot;
        logic [HANDLE_W-1:0] handle;
        logic [KIND_W-1:0]  handle_kind;
        logic [KIND_W-1:0]  want_kind;
    } t_req;

endpackage

`default_nettype wire

### rtl/core/descriptor_slot_table.sv
// Descriptor slot table: lowest-free-slot allocator of device handles.
//
// For each request, the cycle in which start is taken issues the
// entry RAM read and the free-slot search over the occupancy bits, and the
// following cycle (busy high) resolves the request and writes the RAM and
// occupancy back. The result appears on o_done and the result ports for one
// cycle right after that, which is also the earliest cycle a new start is
// taken; no new request is taken while one is in flight, owing to the
// read-modify-write of the registered-read entry RAM. Results cannot be held off.
// Occupancy lives in one flip-flop per slot cleared by reset, so no clearing
// pass runs after reset. Configuration writes are taken in any cycle out of reset.
`default_nettype none

module descriptor_slot_table
    import dst_pkg::*;
#(
    parameter int MAX_SLOTS     = 64,
    parameter int INITIAL_SLOTS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_mode,
    input  wire logic signed [7:0]   i_slot,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [KIND_W-1:0]   i_handle_kind,
    input  wire logic [KIND_W-1:0]   i_want_kind,
    output logic                     o_done,
    output logic [2:0]               o_status,
    output logic [5:0]               o_slot_out,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [KIND_W-1:0]        o_kind_out,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_addr,
    input  wire logic [HANDLE_W-1:0] i_cfg_data
);

    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int CNT_MAX = (MAX_SLOTS > INITIAL_SLOTS) ? MAX_SLOTS : INITIAL_SLOTS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int ENTRY_W = HANDLE_W + KIND_W;
    localparam logic [CNT_W-1:0] CNT_INIT  = CNT_W'(INITIAL_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SLOTS);

    // console registers
    logic [HANDLE_W-1:0] r_con_handle [3];
    logic [KIND_W-1:0]   r_con_kind   [3];

    // table control
    t_state               r_state;
    logic                 r_ready;
    logic [CNT_W-1:0]     r_count;
    logic [MAX_SLOTS-1:0] r_used;
    t_req                 r_req;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;

    // result register
    logic                r_done;
    logic [2:0]          r_status;
    logic [5:0]          r_slot_out;
    logic [HANDLE_W-1:0] r_handle_out;
    logic [KIND_W-1:0]   r_kind_out;

    logic                 accept;
    logic [CNT_W-1:0]     alloc_count;
    logic [MAX_SLOTS-1:0] free_mask;
    logic                 n_free_found;
    logic [IDX_W-1:0]     n_free_idx;

    logic [ENTRY_W-1:0]   rd_entry;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    logic                 n_ready;
    logic [CNT_W-1:0]     n_count;
    logic [MAX_SLOTS-1:0] n_used;
    logic [2:0]           n_status;
    logic [5:0]           n_slot_out;
    logic [HANDLE_W-1:0]  n_handle_out;
    logic [KIND_W-1:0]    n_kind_out;

    logic [CNT_W-1:0]     cnt_eff;
    logic                 in_tab;
    logic [IDX_W-1:0]     slot_idx;
    logic                 is_console;
    logic [HANDLE_W-1:0]  found_handle;
    logic [KIND_W-1:0]    found_kind;
    logic                 found;

    assign accept = start && !busy;
    assign busy   = (r_state == S_EXEC);

    // free-slot search: lowest empty slot from the first non-console slot up
    assign alloc_count = r_ready ? r_count : CNT_INIT;

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            free_mask[i] = !r_used[i] && (i >= FIRST_FREE_SLOT)
                           && (CNT_W'(i) < alloc_count);
        end
    end

    always_comb begin
        n_free_found = 1'b0;
        n_free_idx   = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                n_free_found = 1'b1;
                n_free_idx   = IDX_W'(i);
            end
        end
    end

    dst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({r_req.handle_kind, r_req.handle}),
        .i_raddr (i_slot[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // resolve the request held in r_req
    always_comb begin
        unique case (r_req.mode)
            MODE_ASSIGN, MODE_SET: cnt_eff = r_ready ? r_count : CNT_INIT;
            default:               cnt_eff = r_count;
        endcase

        slot_idx   = r_req.slot[IDX_W-1:0];
        in_tab     = !r_req.slot[7]
                     && ({1'b0, r_req.slot} < {{(9-CNT_W){1'b0}}, cnt_eff})
                     && ({1'b0, r_req.slot} < 9'(MAX_SLOTS));
        is_console = !r_req.slot[7] && (r_req.slot < 8'd3);

        n_ready      = r_ready;
        n_count      = r_count;
        n_used       = r_used;
        n_status     = ST_OK;
        n_slot_out   = r_req.slot[5:0];
        n_handle_out = '0;
        n_kind_out   = '0;
        wr_en        = 1'b0;
        wr_addr      = slot_idx;
        found_handle = '0;
        found_kind   = '0;
        found        = 1'b0;

        if (r_state == S_EXEC) begin
            unique case (r_req.mode)
                MODE_ASSIGN: begin
                    n_ready = 1'b1;
                    n_count = cnt_eff;
                    if (r_free_found) begin
                        wr_en   = 1'b1;
                        wr_addr = r_free_idx;
                    end else if (cnt_eff < CNT_LIMIT) begin
                        // grow by one slot and take the new one
                        wr_en   = 1'b1;
                        wr_addr = cnt_eff[IDX_W-1:0];
                        n_count = cnt_eff + CNT_W'(1);
                    end else begin
                        n_status   = ST_NO_MEMORY;
                        n_slot_out = '0;
                    end
                    if (wr_en) begin
                        n_used[wr_addr] = (r_req.handle != '0);
                        n_slot_out      = 6'({{(8-IDX_W){1'b0}}, wr_addr});
                    end
                end
                MODE_CLEAR: begin
                    if (in_tab) begin
                        n_used[slot_idx] = 1'b0;
                    end else begin
                        n_status = ST_BAD_FD;
                    end
                end
                MODE_SET: begin
                    n_ready = 1'b1;
                    n_count = cnt_eff;
                    if (!in_tab) begin
                        n_status = ST_BAD_FD;
                    end else if (r_used[slot_idx]) begin
                        n_status = ST_IN_USE;
                    end else begin
                        wr_en            = 1'b1;
                        n_used[slot_idx] = (r_req.handle != '0);
                    end
                end
                MODE_GET: begin
                    if (is_console) begin
                        found_handle = r_con_handle[r_req.slot[1:0]];
                        found_kind   = r_con_kind[r_req.slot[1:0]];
                        if (found_handle == '0) begin
                            n_status = ST_NO_CONSOLE;
                        end else begin
                            found = 1'b1;
                        end
                    end else if (!in_tab || !r_used[slot_idx]) begin
                        n_status = ST_BAD_FD;
                    end else begin
                        found_handle = rd_entry[HANDLE_W-1:0];
                        found_kind   = rd_entry[ENTRY_W-1:HANDLE_W];
                        found        = 1'b1;
                    end
                    if (found) begin
                        n_handle_out = found_handle;
                        n_kind_out   = found_kind;
                        if (r_req.want_kind != '0 && found_kind != r_req.want_kind) begin
                            n_status = ST_WRONG_TYPE;
                        end
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_count <= '0;
            r_used  <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_con_handle[i] <= '0;
                r_con_kind[i]   <= '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_ready <= n_ready;
                    r_count <= n_count;
                    r_used  <= n_used;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_STDIN_HANDLE:  r_con_handle[0] <= i_cfg_data;
                    REG_STDOUT_HANDLE: r_con_handle[1] <= i_cfg_data;
                    REG_STDERR_HANDLE: r_con_handle[2] <= i_cfg_data;
                    REG_STDIN_KIND:    r_con_kind[0]   <= i_cfg_data[KIND_W-1:0];
                    REG_STDOUT_KIND:   r_con_kind[1]   <= i_cfg_data[KIND_W-1:0];
                    REG_STDERR_KIND:   r_con_kind[2]   <= i_cfg_data[KIND_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.mode        <= t_mode'(i_mode);
            r_req.slot        <= i_slot;
            r_req.handle      <= i_handle;
            r_req.handle_kind <= i_handle_kind;
            r_req.want_kind   <= i_want_kind;
            r_free_found      <= n_free_found;
            r_free_idx        <= n_free_idx;
        end
        if (r_state == S_EXEC) begin
            r_status     <= n_status;
            r_slot_out   <= n_slot_out;
            r_handle_out <= n_handle_out;
            r_kind_out   <= n_kind_out;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_handle_out = r_handle_out;
    assign o_kind_out   = r_kind_out;

endmodule

`default_nettype wire

### rtl/core/dst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dst_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
